// ----- hw/rtl/twrc_pkg.sv -----
// Shared types, codes and constants of the TFTP windowed read client.
package twrc_pkg;

  // Protocol constants
  localparam logic [10:0] MAX_BLOCK       = 11'd1468;
  localparam logic [3:0]  MAX_WINDOW      = 4'd8;
  localparam logic [15:0] WELL_KNOWN_PORT = 16'd69;
  localparam logic [10:0] DEFAULT_BLOCK   = 11'd512;
  localparam logic [15:0] TID_PORT_BASE   = 16'd20069;
  localparam logic [10:0] MIN_BLOCK       = 11'd8;
  localparam logic [3:0]  RETRY_RESET     = 4'd4;

  // Result queue sizing: one event yields at most three results
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int MAX_RES = 3;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_SERVER   = 2'd1;
  localparam logic [1:0] REG_RETRY    = 2'd2;

  // Event kinds
  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_TIMEOUT = 3'd1;
  localparam logic [2:0] KIND_DATA    = 3'd2;
  localparam logic [2:0] KIND_ERROR   = 3'd3;
  localparam logic [2:0] KIND_OACK    = 3'd4;

  // Result actions
  localparam logic [2:0] ACT_REQ_OPT   = 3'd0;
  localparam logic [2:0] ACT_REQ_PLAIN = 3'd1;
  localparam logic [2:0] ACT_ACK       = 3'd2;
  localparam logic [2:0] ACT_STORE     = 3'd3;
  localparam logic [2:0] ACT_REPORT    = 3'd4;
  localparam logic [2:0] ACT_DONE      = 3'd5;
  localparam logic [2:0] ACT_FAILED    = 3'd6;

  // Failure status
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_ANSWER  = 3'd1;
  localparam logic [2:0] ST_REFUSED    = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] block_number;
    logic [10:0] payload_length;
    logic [15:0] source_port;
    logic [31:0] granted_tsize;
    logic [31:0] granted_blksize;
    logic [31:0] granted_window;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] ack_block;
    logic [15:0] dest_port;
    logic [15:0] own_port;
    logic [31:0] write_offset;
    logic [31:0] byte_count;
    logic [2:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]             n;
    result_t [MAX_RES-1:0]  res;
  } push_t;

  typedef struct packed {
    logic [31:0] buffer_capacity;
    logic [31:0] server_address;
    logic [3:0]  retry_limit;
  } cfg_t;

  function automatic result_t make_res(logic [2:0] action, logic [15:0] ack_block,
                                       logic [15:0] dest_port, logic [15:0] own_port,
                                       logic [31:0] write_offset, logic [31:0] byte_count,
                                       logic [2:0] status);
    result_t r;
    r.action       = action;
    r.ack_block    = ack_block;
    r.dest_port    = dest_port;
    r.own_port     = own_port;
    r.write_offset = write_offset;
    r.byte_count   = byte_count;
    r.status       = status;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

// ----- hw/rtl/tftp_windowed_read_client_unit.sv -----
// Top level of the TFTP windowed read client.
//
// Each input item (start, timeout, or a classified packet) is registered, then
// processed in a single pass against the transfer state; it yields zero to three
// result items, written together into a four-entry result queue that sends one
// item per cycle while the output is ready. An item whose work leaves at most
// one result can follow in every cycle while the output is ready; the input
// stalls only while the queue holds fewer than three free entries. The first
// result of an item passes through the input register and then the result
// queue, and waits in the input register while the queue lacks room.
// No clearing pass follows reset.
module tftp_windowed_read_client_unit
  import twrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_kind,
  input  logic [15:0]       in_block_number,
  input  logic [10:0]       in_payload_length,
  input  logic [15:0]       in_source_port,
  input  logic [31:0]       in_granted_tsize,
  input  logic [31:0]       in_granted_blksize,
  input  logic [31:0]       in_granted_window,
  // Result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_action,
  output logic [15:0]       out_ack_block,
  output logic [15:0]       out_dest_port,
  output logic [15:0]       out_own_port,
  output logic [31:0]       out_write_offset,
  output logic [31:0]       out_byte_count,
  output logic [2:0]        out_status,
  output logic              out_last,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t     cfg;
  in_item_t in_item;
  push_t    push;
  logic     push_en;
  logic     room;
  result_t  out_item;

  // Gather the input fields
  assign in_item.kind            = in_kind;
  assign in_item.block_number    = in_block_number;
  assign in_item.payload_length  = in_payload_length;
  assign in_item.source_port     = in_source_port;
  assign in_item.granted_tsize   = in_granted_tsize;
  assign in_item.granted_blksize = in_granted_blksize;
  assign in_item.granted_window  = in_granted_window;

  twrc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  twrc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cfg      (cfg),
    .room     (room),
    .push_en  (push_en),
    .push     (push)
  );

  twrc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (push_en),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Spread the result fields
  assign out_action       = out_item.action;
  assign out_ack_block    = out_item.ack_block;
  assign out_dest_port    = out_item.dest_port;
  assign out_own_port     = out_item.own_port;
  assign out_write_offset = out_item.write_offset;
  assign out_byte_count   = out_item.byte_count;
  assign out_status       = out_item.status;
  assign out_last         = out_item.last;

endmodule

// ----- hw/rtl/twrc_cfg.sv -----
// Configuration registers behind the APB-style port.
module twrc_cfg
  import twrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [31:0] capacity_r;
  logic [31:0] server_r;
  logic [3:0]  retry_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 32'd0;
      server_r   <= 32'd0;
      retry_r    <= RETRY_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CAPACITY: capacity_r <= pwdata;
        REG_SERVER:   server_r   <= pwdata;
        REG_RETRY:    retry_r    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_CAPACITY: prdata = capacity_r;
      REG_SERVER:   prdata = server_r;
      REG_RETRY:    prdata = {28'd0, retry_r};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg.buffer_capacity = capacity_r;
  assign cfg.server_address  = server_r;
  assign cfg.retry_limit     = retry_r;

endmodule

// ----- hw/rtl/twrc_core.sv -----
// Input register, transfer state and the single-pass event logic.
module twrc_core
  import twrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  cfg_t     cfg,
  input  logic     room,
  output logic     push_en,
  output push_t    push
);

  // Input stage
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     s1_go;

  // Transfer state
  logic        active_r,   active_nxt;
  logic [15:0] exp_r,      exp_nxt;
  logic [31:0] bytes_r,    bytes_nxt;
  logic [15:0] peer_r,     peer_nxt;
  logic [15:0] rport_r,    rport_nxt;
  logic [10:0] nblock_r,   nblock_nxt;
  logic [3:0]  nwin_r,     nwin_nxt;
  logic [3:0]  bsa_r,      bsa_nxt;
  logic [31:0] promised_r, promised_nxt;
  logic        opt_r,      opt_nxt;
  logic        resend_r,   resend_nxt;
  logic [3:0]  tc_r,       tc_nxt;

  push_t push_c;

  assign s1_go    = s1_valid_r & room;
  assign in_ready = ~s1_valid_r | s1_go;
  assign push_en  = s1_go;
  assign push     = push_c;

  // Repeat the request, or the pending acknowledgement
  function automatic result_t speak_res(logic [15:0] exp, logic [31:0] bytes,
                                        logic [15:0] peer, logic opt, logic [15:0] rport);
    result_t r;
    if (exp == 16'd1 && bytes == 32'd0 && peer == WELL_KNOWN_PORT) begin
      r = make_res(opt ? ACT_REQ_OPT : ACT_REQ_PLAIN, 16'd0, WELL_KNOWN_PORT, rport,
                   32'd0, 32'd0, ST_OK);
    end else begin
      r = make_res(ACT_ACK, exp - 16'd1, peer, rport, 32'd0, 32'd0, ST_OK);
    end
    return r;
  endfunction

  // Event logic: next state and up to three results
  always_comb begin
    logic [1:0]  n;
    logic [10:0] len_c;
    logic [32:0] sum;
    logic [15:0] rp1;

    active_nxt   = active_r;
    exp_nxt      = exp_r;
    bytes_nxt    = bytes_r;
    peer_nxt     = peer_r;
    rport_nxt    = rport_r;
    nblock_nxt   = nblock_r;
    nwin_nxt     = nwin_r;
    bsa_nxt      = bsa_r;
    promised_nxt = promised_r;
    opt_nxt      = opt_r;
    resend_nxt   = resend_r;
    tc_nxt       = tc_r;
    push_c       = '0;
    n            = 2'd0;
    len_c        = (s1_item_r.payload_length > MAX_BLOCK) ? MAX_BLOCK
                                                          : s1_item_r.payload_length;
    sum          = {1'b0, bytes_r} + {22'd0, len_c};
    rp1          = 16'd0;

    if (s1_item_r.kind == KIND_START) begin
      // Clear the transfer and open a new one if a server address is set
      active_nxt   = 1'b0;
      exp_nxt      = 16'd1;
      bytes_nxt    = 32'd0;
      peer_nxt     = WELL_KNOWN_PORT;
      nblock_nxt   = DEFAULT_BLOCK;
      nwin_nxt     = 4'd1;
      bsa_nxt      = 4'd0;
      promised_nxt = 32'd0;
      opt_nxt      = 1'b1;
      resend_nxt   = 1'b0;
      tc_nxt       = 4'd0;
      if (cfg.server_address == 32'd0) begin
        push_c.res[0] = make_res(ACT_FAILED, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0,
                                 ST_NO_ANSWER);
        n = 2'd1;
      end else begin
        rp1 = ((rport_r == 16'd0) ? TID_PORT_BASE : rport_r) + 16'd1;
        rport_nxt  = (rp1 < TID_PORT_BASE) ? TID_PORT_BASE : rp1;
        active_nxt = 1'b1;
        push_c.res[0] = make_res(ACT_REQ_OPT, 16'd0, WELL_KNOWN_PORT, rport_nxt,
                                 32'd0, 32'd0, ST_OK);
        n = 2'd1;
      end
    end else if (active_r) begin
      unique case (s1_item_r.kind)
        KIND_TIMEOUT: begin
          tc_nxt = (tc_r < 4'd15) ? tc_r + 4'd1 : tc_r;
          if (tc_nxt >= cfg.retry_limit) begin
            if (opt_r && bytes_r == 32'd0) begin
              // Fall back to a plain request
              opt_nxt = 1'b0;
              tc_nxt  = 4'd0;
              push_c.res[0] = speak_res(exp_r, bytes_r, peer_r, 1'b0, rport_r);
            end else begin
              active_nxt = 1'b0;
              push_c.res[0] = make_res(ACT_FAILED, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0,
                                       ST_NO_ANSWER);
            end
          end else begin
            bsa_nxt = 4'd0;
            push_c.res[0] = speak_res(exp_r, bytes_r, peer_r, opt_r, rport_r);
          end
          n = 2'd1;
        end
        KIND_DATA: begin
          tc_nxt   = 4'd0;
          peer_nxt = s1_item_r.source_port;
          if (s1_item_r.block_number != exp_r) begin
            // Ask for a resend only once
            if (!resend_r) begin
              resend_nxt = 1'b1;
              bsa_nxt    = 4'd0;
              push_c.res[0] = speak_res(exp_r, bytes_r, peer_nxt, opt_r, rport_r);
              n = 2'd1;
            end
          end else begin
            resend_nxt = 1'b0;
            if (sum > {1'b0, cfg.buffer_capacity}) begin
              active_nxt = 1'b0;
              push_c.res[0] = make_res(ACT_FAILED, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0,
                                       ST_TOO_LARGE);
              n = 2'd1;
            end else begin
              push_c.res[0] = make_res(ACT_STORE, 16'd0, 16'd0, 16'd0, bytes_r,
                                       {21'd0, len_c}, ST_OK);
              n         = 2'd1;
              bytes_nxt = sum[31:0];
              exp_nxt   = exp_r + 16'd1;
              bsa_nxt   = (bsa_r < 4'd15) ? bsa_r + 4'd1 : bsa_r;
              if (len_c < nblock_r) begin
                // Short block ends the transfer
                push_c.res[1] = make_res(ACT_ACK, exp_r, peer_nxt, rport_r, 32'd0,
                                         32'd0, ST_OK);
                active_nxt = 1'b0;
                if (promised_r != 32'd0 && bytes_nxt != promised_r) begin
                  push_c.res[2] = make_res(ACT_FAILED, 16'd0, 16'd0, 16'd0, 32'd0,
                                           32'd0, ST_INCOMPLETE);
                end else begin
                  push_c.res[2] = make_res(ACT_DONE, 16'd0, 16'd0, 16'd0, 32'd0,
                                           bytes_nxt, ST_OK);
                end
                n = 2'd3;
              end else if (bsa_nxt >= nwin_r) begin
                // Acknowledge once per window
                bsa_nxt = 4'd0;
                push_c.res[1] = speak_res(exp_nxt, bytes_nxt, peer_nxt, opt_r, rport_r);
                n = 2'd2;
              end
            end
          end
        end
        KIND_ERROR: begin
          tc_nxt     = 4'd0;
          active_nxt = 1'b0;
          push_c.res[0] = make_res(ACT_FAILED, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0,
                                   ST_REFUSED);
          n = 2'd1;
        end
        KIND_OACK: begin
          tc_nxt   = 4'd0;
          peer_nxt = s1_item_r.source_port;
          if (s1_item_r.granted_tsize != 32'd0) begin
            promised_nxt = s1_item_r.granted_tsize;
            push_c.res[0] = make_res(ACT_REPORT, 16'd0, 16'd0, 16'd0, 32'd0,
                                     s1_item_r.granted_tsize, ST_OK);
            n = 2'd1;
          end
          if (s1_item_r.granted_blksize >= {21'd0, MIN_BLOCK} &&
              s1_item_r.granted_blksize <= {21'd0, MAX_BLOCK}) begin
            nblock_nxt = s1_item_r.granted_blksize[10:0];
          end
          if (s1_item_r.granted_window >= 32'd1 &&
              s1_item_r.granted_window <= {28'd0, MAX_WINDOW}) begin
            nwin_nxt = s1_item_r.granted_window[3:0];
          end
          if (n == 2'd0) begin
            push_c.res[0] = make_res(ACT_ACK, 16'd0, peer_nxt, rport_r, 32'd0, 32'd0,
                                     ST_OK);
          end else begin
            push_c.res[1] = make_res(ACT_ACK, 16'd0, peer_nxt, rport_r, 32'd0, 32'd0,
                                     ST_OK);
          end
          n       = n + 2'd1;
          bsa_nxt = 4'd0;
        end
        default: begin
          tc_nxt = 4'd0;
        end
      endcase
    end

    // Mark the final result of this item
    case (n)
      2'd1:    push_c.res[0].last = 1'b1;
      2'd2:    push_c.res[1].last = 1'b1;
      2'd3:    push_c.res[2].last = 1'b1;
      default: ;
    endcase
    push_c.n = n;
  end

  // Hold the input item and the transfer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      active_r   <= 1'b0;
      exp_r      <= 16'd1;
      bytes_r    <= 32'd0;
      peer_r     <= WELL_KNOWN_PORT;
      rport_r    <= 16'd0;
      nblock_r   <= DEFAULT_BLOCK;
      nwin_r     <= 4'd1;
      bsa_r      <= 4'd0;
      promised_r <= 32'd0;
      opt_r      <= 1'b1;
      resend_r   <= 1'b0;
      tc_r       <= 4'd0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        active_r   <= active_nxt;
        exp_r      <= exp_nxt;
        bytes_r    <= bytes_nxt;
        peer_r     <= peer_nxt;
        rport_r    <= rport_nxt;
        nblock_r   <= nblock_nxt;
        nwin_r     <= nwin_nxt;
        bsa_r      <= bsa_nxt;
        promised_r <= promised_nxt;
        opt_r      <= opt_nxt;
        resend_r   <= resend_nxt;
        tc_r       <= tc_nxt;
      end
    end
  end

  // Capture the payload of an accepted item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

endmodule

// ----- hw/rtl/twrc_outq.sv -----
// Result queue: takes up to three results per cycle, delivers one per cycle while the output is ready.
module twrc_outq
  import twrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_en,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  result_t      q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;
  logic           pop;
  logic [QAW:0]   count_after_pop;
  logic [1:0]     n_push;

  assign out_valid       = (count_r != '0);
  assign out_item        = q_r[rd_ptr_r];
  assign pop             = out_valid & out_ready;
  assign count_after_pop = count_r - {{QAW{1'b0}}, pop};
  assign room            = (count_after_pop <= (QAW+1)'(QDEPTH - MAX_RES));
  assign n_push          = push_en ? push.n : 2'd0;

  // Write the new results in order
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (k < int'(n_push)) begin
        q_r[wr_ptr_r + QAW'(k)] <= push.res[k];
      end
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QAW'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_after_pop + (QAW+1)'(n_push);
    end
  end

endmodule

// ----- bench/tb_tftp_windowed_read_client_unit.sv -----
// Testbench for the TFTP windowed read client: random and directed events checked against a predictor.
`timescale 1ns / 100ps

module tb_tftp_windowed_read_client_unit
  import twrc_pkg::*;
();

  // Event kinds that the package leaves unnamed
  localparam logic [2:0] KIND_OTHER    = 3'd5;
  localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_kind;
  logic [15:0] in_block_number;
  logic [10:0] in_payload_length;
  logic [15:0] in_source_port;
  logic [31:0] in_granted_tsize;
  logic [31:0] in_granted_blksize;
  logic [31:0] in_granted_window;

  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_action;
  logic [15:0] out_ack_block;
  logic [15:0] out_dest_port;
  logic [15:0] out_own_port;
  logic [31:0] out_write_offset;
  logic [31:0] out_byte_count;
  logic [2:0]  out_status;
  logic        out_last;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  tftp_windowed_read_client_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_block_number(in_block_number), .in_payload_length(in_payload_length),
    .in_source_port(in_source_port), .in_granted_tsize(in_granted_tsize),
    .in_granted_blksize(in_granted_blksize), .in_granted_window(in_granted_window),
    .out_valid(out_valid), .out_ready(out_ready), .out_action(out_action),
    .out_ack_block(out_ack_block), .out_dest_port(out_dest_port),
    .out_own_port(out_own_port), .out_write_offset(out_write_offset),
    .out_byte_count(out_byte_count), .out_status(out_status), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Stimulus and expectations
  in_item_t pending_items[$];
  result_t  expected_results[$];
  int       phase_items;
  int       items_sent;
  int       items_accepted;
  int       mismatches;
  int       quiet_cycles;
  int       in_gap;
  int       out_gap;
  int       idle_odds;
  bit       calm_phase;

  // Predictor configuration
  logic [31:0] cap_bytes;
  logic [31:0] server_ip;
  logic [3:0]  retry_max;

  // Predictor transfer state
  logic        xfer_active;
  logic [15:0] next_block;
  logic [31:0] rx_bytes;
  logic [15:0] peer_port;
  logic [15:0] tid_port;
  logic [10:0] blk_size;
  logic [3:0]  win_size;
  logic [3:0]  unacked;
  logic [31:0] promised;
  logic        opts_on;
  logic        resend_sent;
  logic [3:0]  timeouts;

  // Results of the event being predicted
  result_t     step_res[3];
  int          step_n;

  function automatic void add_result(logic [2:0] act, logic [15:0] ackb, logic [15:0] dport,
                                     logic [15:0] oport, logic [31:0] offs,
                                     logic [31:0] nbytes, logic [2:0] st);
    result_t r;
    r.action       = act;
    r.ack_block    = ackb;
    r.dest_port    = dport;
    r.own_port     = oport;
    r.write_offset = offs;
    r.byte_count   = nbytes;
    r.status       = st;
    r.last         = 1'b0;
    if (step_n < 3) begin
      step_res[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic void abort_transfer(logic [2:0] st);
    xfer_active = 1'b0;
    add_result(ACT_FAILED, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0, st);
  endfunction

  function automatic void add_ack(logic [15:0] blk);
    add_result(ACT_ACK, blk, peer_port, tid_port, 32'd0, 32'd0, ST_OK);
  endfunction

  // Repeat the request while nothing came back, else the pending ack
  function automatic void repeat_last();
    if (next_block == 16'd1 && rx_bytes == 32'd0 && peer_port == WELL_KNOWN_PORT)
      add_result(opts_on ? ACT_REQ_OPT : ACT_REQ_PLAIN, 16'd0, WELL_KNOWN_PORT,
                 tid_port, 32'd0, 32'd0, ST_OK);
    else
      add_ack(next_block - 16'd1);
  endfunction

  function automatic void clear_transfer();
    xfer_active = 1'b0;
    next_block  = 16'd1;
    rx_bytes    = 32'd0;
    peer_port   = WELL_KNOWN_PORT;
    blk_size    = DEFAULT_BLOCK;
    win_size    = 4'd1;
    unacked     = 4'd0;
    promised    = 32'd0;
    opts_on     = 1'b1;
    resend_sent = 1'b0;
    timeouts    = 4'd0;
  endfunction

  function automatic void take_block(logic [15:0] blk, logic [10:0] n, logic [15:0] port);
    timeouts  = 4'd0;
    peer_port = port;
    if (blk != next_block) begin
      // ask for a resend only on the first stray block
      if (!resend_sent) begin
        resend_sent = 1'b1;
        unacked     = 4'd0;
        repeat_last();
      end
    end else begin
      resend_sent = 1'b0;
      if (({1'b0, rx_bytes} + {22'd0, n}) > {1'b0, cap_bytes}) begin
        abort_transfer(ST_TOO_LARGE);
      end else begin
        add_result(ACT_STORE, 16'd0, 16'd0, 16'd0, rx_bytes, {21'd0, n}, ST_OK);
        rx_bytes   = rx_bytes + {21'd0, n};
        next_block = next_block + 16'd1;
        if (unacked < 4'd15) unacked = unacked + 4'd1;
        if (n < blk_size) begin
          // short block closes the transfer
          add_ack(next_block - 16'd1);
          xfer_active = 1'b0;
          if (promised != 32'd0 && rx_bytes != promised)
            abort_transfer(ST_INCOMPLETE);
          else
            add_result(ACT_DONE, 16'd0, 16'd0, 16'd0, 32'd0, rx_bytes, ST_OK);
        end else if (unacked >= win_size) begin
          unacked = 4'd0;
          repeat_last();
        end
      end
    end
  endfunction

  function automatic void predict_item(in_item_t it);
    logic [10:0] n;
    result_t     r;
    step_n = 0;
    n = (it.payload_length > MAX_BLOCK) ? MAX_BLOCK : it.payload_length;
    if (it.kind == KIND_START) begin
      clear_transfer();
      if (server_ip == 32'd0) begin
        abort_transfer(ST_NO_ANSWER);
      end else begin
        if (tid_port == 16'd0) tid_port = TID_PORT_BASE;
        tid_port = tid_port + 16'd1;
        if (tid_port < TID_PORT_BASE) tid_port = TID_PORT_BASE;
        xfer_active = 1'b1;
        repeat_last();
      end
    end else if (xfer_active) begin
      case (it.kind)
        KIND_TIMEOUT: begin
          if (timeouts < 4'd15) timeouts = timeouts + 4'd1;
          if (timeouts >= retry_max) begin
            // fall back once to a request without options
            if (opts_on && rx_bytes == 32'd0) begin
              opts_on  = 1'b0;
              timeouts = 4'd0;
              repeat_last();
            end else begin
              abort_transfer(ST_NO_ANSWER);
            end
          end else begin
            unacked = 4'd0;
            repeat_last();
          end
        end
        KIND_DATA: take_block(it.block_number, n, it.source_port);
        KIND_ERROR: begin
          timeouts = 4'd0;
          abort_transfer(ST_REFUSED);
        end
        KIND_OACK: begin
          timeouts  = 4'd0;
          peer_port = it.source_port;
          if (it.granted_tsize != 32'd0) begin
            promised = it.granted_tsize;
            add_result(ACT_REPORT, 16'd0, 16'd0, 16'd0, 32'd0, it.granted_tsize, ST_OK);
          end
          if (it.granted_blksize >= MIN_BLOCK && it.granted_blksize <= MAX_BLOCK)
            blk_size = it.granted_blksize[10:0];
          if (it.granted_window >= 32'd1 && it.granted_window <= MAX_WINDOW)
            win_size = it.granted_window[3:0];
          add_ack(16'd0);
          unacked = 4'd0;
        end
        default: timeouts = 4'd0;
      endcase
    end
    for (int i = 0; i < step_n; i++) begin
      r = step_res[i];
      r.last = (i == step_n - 1);
      expected_results.push_back(r);
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: predict on accepted items, check accepted results, guard against hangs
  in_item_t seen_item;
  result_t  exp_r;
  logic     moved;

  always @(posedge clk) begin
    if (rst_n) begin
      moved = psel;
      if (in_valid && in_ready) begin
        seen_item = {in_kind, in_block_number, in_payload_length, in_source_port,
                     in_granted_tsize, in_granted_blksize, in_granted_window};
        predict_item(seen_item);
        items_accepted <= items_accepted + 1;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: action %0d", out_action);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("action", exp_r.action, out_action);
          check_field("ack_block", exp_r.ack_block, out_ack_block);
          check_field("dest_port", exp_r.dest_port, out_dest_port);
          check_field("own_port", exp_r.own_port, out_own_port);
          check_field("write_offset", exp_r.write_offset, out_write_offset);
          check_field("byte_count", exp_r.byte_count, out_byte_count);
          check_field("status", exp_r.status, out_status);
          check_field("last", exp_r.last, out_last);
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Driver: present pending items, idle in random bursts
  in_item_t nxt;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || items_sent == items_accepted)) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, idle_odds) == 0) begin
        in_gap   <= $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        in_kind            <= nxt.kind;
        in_block_number    <= nxt.block_number;
        in_payload_length  <= nxt.payload_length;
        in_source_port     <= nxt.source_port;
        in_granted_tsize   <= nxt.granted_tsize;
        in_granted_blksize <= nxt.granted_blksize;
        in_granted_window  <= nxt.granted_window;
        in_valid           <= 1'b1;
        items_sent         <= items_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: stall in random bursts
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap   <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm_phase && $urandom_range(0, idle_odds) == 0) begin
      out_gap   <= $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic add_item(input logic [2:0] k, input logic [15:0] blk, input logic [10:0] len,
                          input logic [15:0] port, input logic [31:0] ts,
                          input logic [31:0] bs, input logic [31:0] ws);
    in_item_t it;
    it.kind            = k;
    it.block_number    = blk;
    it.payload_length  = len;
    it.source_port     = port;
    it.granted_tsize   = ts;
    it.granted_blksize = bs;
    it.granted_window  = ws;
    pending_items.push_back(it);
    phase_items++;
  endtask

  // Event whose packet fields carry random bits
  task automatic add_event(input logic [2:0] k);
    logic [31:0] r1, r2, r3;
    r1 = $urandom;
    r2 = $urandom;
    r3 = $urandom;
    add_item(k, r1[15:0], r1[26:16], r2[15:0], $urandom, $urandom, r3);
  endtask

  // One read transfer, mostly well formed, with timeouts, strays and aborts mixed in
  task automatic add_transfer();
    logic [31:0] r, tsz, bsz, wsz;
    logic [15:0] port, blk;
    logic [10:0] bgen, len, tail;
    logic [2:0]  k;
    int unsigned nfull, total;
    bit          use_oack, cut;
    add_event(KIND_START);
    r = $urandom;
    port = r[15:0];
    bgen = DEFAULT_BLOCK;
    bsz = $urandom;
    wsz = $urandom;
    use_oack = ($urandom_range(0, 2) != 0);
    if (use_oack) begin
      case ($urandom_range(0, 4))
        0: bsz = {21'd0, MIN_BLOCK};
        1: bsz = {21'd0, MAX_BLOCK};
        2: bsz = $urandom_range(MIN_BLOCK, MAX_BLOCK);
        3: bsz = $urandom_range(0, 1) ? {21'd0, MIN_BLOCK} - 32'd1 : {21'd0, MAX_BLOCK} + 32'd1;
        default: ;
      endcase
      if (bsz >= MIN_BLOCK && bsz <= MAX_BLOCK) bgen = bsz[10:0];
      case ($urandom_range(0, 4))
        0: wsz = 32'd1;
        1: wsz = {28'd0, MAX_WINDOW};
        2: wsz = $urandom_range(1, MAX_WINDOW);
        3: wsz = $urandom_range(0, 1) ? 32'd0 : {28'd0, MAX_WINDOW} + 32'd1;
        default: ;
      endcase
    end
    nfull = $urandom_range(0, (bgen < 11'd64) ? 8 : 3);
    tail  = 11'($urandom_range(0, bgen - 11'd1));
    total = nfull * bgen + tail;
    case ($urandom_range(0, 3))
      0, 1: tsz = total;
      2: tsz = 32'd0;
      default: tsz = $urandom;
    endcase
    repeat ($urandom_range(0, 1)) add_event(KIND_TIMEOUT);
    if (use_oack) begin
      r = $urandom;
      add_item(KIND_OACK, r[15:0], r[26:16], port, tsz, bsz, wsz);
    end
    cut = 1'b0;
    for (int unsigned i = 0; i <= nfull && !cut; i++) begin
      blk = 16'(i + 1);
      r = $urandom;
      case ($urandom_range(0, 11))
        0: add_event(KIND_TIMEOUT);
        1: add_item(KIND_DATA, blk + 16'd1 + r[3:0], bgen, port, r, r, r);
        2: add_item(KIND_DATA, r[31:16], r[10:0], port, r, r, r);
        3: if (i > 0) add_item(KIND_DATA, blk - 16'd1, bgen, port, r, r, r);
        4: begin
          k = 3'($urandom_range(KIND_OTHER, KIND_UNUSED_7));
          add_event(k);
        end
        5: if ($urandom_range(0, 2) == 0) begin
          add_event($urandom_range(0, 1) ? KIND_ERROR : KIND_START);
          cut = 1'b1;
        end
        default: ;
      endcase
      if (!cut) begin
        if (i == nfull) len = tail;
        else if (bgen == MAX_BLOCK && r[20]) len = 11'($urandom_range(MAX_BLOCK, 2047));
        else len = bgen;
        r = $urandom;
        add_item(KIND_DATA, blk, len, port, $urandom, r, $urandom);
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CAPACITY: cap_bytes = val;
      REG_SERVER:   server_ip = val;
      default:      retry_max = val[3:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] cap, input logic [31:0] srv,
                            input logic [3:0] retries);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_SERVER, srv);
    write_reg(REG_RETRY, {28'd0, retries});
  endtask

  // Let everything drain, then allow the pipeline to settle
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    in_valid = 1'b0;
    in_kind = KIND_START;
    in_block_number = 16'd0;
    in_payload_length = 11'd0;
    in_source_port = 16'd0;
    in_granted_tsize = 32'd0;
    in_granted_blksize = 32'd0;
    in_granted_window = 32'd0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'd0;
    items_sent = 0;
    items_accepted = 0;
    mismatches = 0;
    quiet_cycles = 0;
    in_gap = 0;
    out_gap = 0;
    idle_odds = 6;
    calm_phase = 1'b0;
    phase_items = 0;
    cap_bytes = 32'd0;
    server_ip = 32'd0;
    retry_max = RETRY_RESET;
    tid_port = 16'd0;
    clear_transfer();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // No server configured yet; idle block ignores a timeout
    add_event(KIND_START);
    add_event(KIND_TIMEOUT);
    wait_drained();
    set_config(32'hFFFF_FFFF, 32'hC0A8_0001, 4'd2);

    // Windowed transfer with a stray block, an oversized block and a size mismatch
    add_item(KIND_START, 16'hFFFF, 11'h7FF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(KIND_OACK, 16'd0, 11'd0, 16'hFFFF, 32'd2000, 32'd1000, 32'd2);
    add_item(KIND_DATA, 16'd1, 11'd1000, 16'hFFFF, 32'd0, 32'd0, 32'd0);
    add_item(KIND_DATA, 16'd3, 11'd1000, 16'hFFFF, 32'd0, 32'd0, 32'd0);
    add_item(KIND_DATA, 16'd3, 11'd1000, 16'hFFFF, 32'd0, 32'd0, 32'd0);
    add_item(KIND_DATA, 16'd2, 11'h7FF, 16'hFFFF, 32'd0, 32'd0, 32'd0);
    add_item(KIND_DATA, 16'd3, 11'd0, 16'hFFFF, 32'd0, 32'd0, 32'd0);
    add_event(KIND_ERROR);
    // Timeouts: request again, fall back to a plain request, then give up
    add_event(KIND_START);
    add_event(KIND_TIMEOUT);
    add_event(KIND_TIMEOUT);
    add_event(KIND_OTHER);
    add_event(KIND_TIMEOUT);
    add_event(KIND_TIMEOUT);
    // Invalid options, an absent size that keeps the promise, unused kinds
    add_event(KIND_START);
    add_item(KIND_OACK, 16'd0, 11'd0, 16'd0, 32'd5000, 32'd7, 32'd9);
    add_item(KIND_OACK, 16'd0, 11'd0, 16'd1234, 32'd0, {21'd0, MAX_BLOCK}, {28'd0, MAX_WINDOW});
    add_event(KIND_UNUSED_6);
    add_event(KIND_UNUSED_7);
    add_item(KIND_DATA, 16'd1, 11'd100, 16'd1234, 32'd0, 32'd0, 32'd0);
    // Refusal, restart while active, empty file
    add_event(KIND_START);
    add_event(KIND_ERROR);
    add_event(KIND_START);
    add_event(KIND_START);
    add_item(KIND_DATA, 16'd1, 11'd0, 16'd0, 32'd0, 32'd0, 32'd0);
    wait_drained();

    // Random transfers under several settings, the last one without idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin set_config(32'hFFFF_FFFF, $urandom | 32'd1, 4'd15); idle_odds = 3; end
        1: begin set_config($urandom_range(1000, 6000), 32'hFFFF_FFFF, 4'd0); idle_odds = 8; end
        2: begin set_config(32'd0, 32'd1, 4'd1); idle_odds = 20; end
        3: begin set_config(32'hFFFF_FFFF, 32'd0, 4'd3); idle_odds = 5; end
        4: begin
          set_config($urandom_range(2000, 20000), $urandom | 32'd1, $urandom_range(1, 15));
          idle_odds = 40;
        end
        default: begin
          set_config($urandom, $urandom | 32'd1, 4'd2);
          calm_phase = 1'b1;
        end
      endcase
      phase_items = 0;
      while (phase_items < ((ph == 3) ? 5 : ((ph == 2) ? 10 : 15))) add_transfer();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/twrc_pkg.sv
hw/rtl/twrc_cfg.sv
hw/rtl/twrc_core.sv
hw/rtl/twrc_outq.sv
hw/rtl/tftp_windowed_read_client_unit.sv
bench/tb_tftp_windowed_read_client_unit.sv
